// ----- rtl/safeguarded_newton_root_solver_defines.svh -----
// Assertion macros for the safeguarded Newton root solver.
// No dependencies; modules that check themselves include this file.
`ifndef SAFEGUARDED_NEWTON_ROOT_SOLVER_DEFINES_SVH
`define SAFEGUARDED_NEWTON_ROOT_SOLVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SNR_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("solver check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SNR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("solver check failed");

`endif

// ----- rtl/snr_pkg.sv -----
// Shared types and constants for the safeguarded Newton root solver.
// No dependencies; the solver modules refer to it by scoped names.
package snr_pkg;

    localparam int COEF_W    = 32;
    localparam int ROOT_W    = 25;
    localparam int STEPS_W   = 8;
    localparam int TOL_W     = 25;
    localparam int CFG_IDX_W = 8;

    // Shared multiplier and divider widths
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 34;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 8'd1;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 25'd17;
    localparam logic [STEPS_W-1:0] LIMIT_RESET = 8'd100;

    typedef struct packed {
        logic [COEF_W-1:0] coef_linear;
        logic [COEF_W-1:0] coef_ratio;
        logic [COEF_W-1:0] target_value;
    } in_item_t;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [STEPS_W-1:0] steps_taken;
        logic               limit_reached;
    } out_item_t;

    // Divider launch request
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_req_t;

endpackage

// ----- rtl/snr_mul.sv -----
// Shared registered multiplier of the root solver.
// Depends on snr_pkg for operand widths.
module snr_mul (
    input  logic                        clk,
    input  logic                        en,
    input  logic [snr_pkg::MUL_A_W-1:0] a,
    input  logic [snr_pkg::MUL_B_W-1:0] b,
    output logic [snr_pkg::PROD_W-1:0]  prod
);

    logic [snr_pkg::PROD_W-1:0] prod_reg;

    // Capture the product when the sequencer issues operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/snr_div.sv -----
// Shared restoring divider of the root solver, one quotient bit per cycle.
// Depends on snr_pkg for widths and the request struct.
module snr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  snr_pkg::div_req_t             req,
    input  logic [snr_pkg::DIV_W-1:0]     rem_init,
    input  logic [snr_pkg::DIV_W-1:0]     dividend,
    input  logic [snr_pkg::DIV_W-1:0]     divisor,
    output logic                          done,
    output logic [snr_pkg::DIV_W-1:0]     quotient
);

    localparam int W = snr_pkg::DIV_W;

    logic                            run_reg;
    logic                            done_reg;
    logic [snr_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [W-1:0]                    rem_reg;
    logic [W-1:0]                    dvd_reg;
    logic [W-1:0]                    dsr_reg;
    logic [W-1:0]                    quo_reg;
    logic [W:0]                      trial;
    logic [W:0]                      trial_diff;
    logic                            fits;
    logic [W-1:0]                    rem_next;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[W-1]};
        trial_diff = trial - {1'b0, dsr_reg};
        fits       = trial >= {1'b0, dsr_reg};
        rem_next   = fits ? trial_diff[W-1:0] : trial[W-1:0];
    end

    // Sequence the iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.count;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - snr_pkg::DIV_CNT_W'(1);
            if (cnt_reg == snr_pkg::DIV_CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Load operands, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/safeguarded_newton_root_solver.sv -----
// One item at a time: a new transfer is taken in the cycle after the result
// transfer. Reset clears control and sets tolerance 17 and iteration limit 100.
// Depends on snr_pkg, snr_mul, snr_div and the solver defines header.
`include "safeguarded_newton_root_solver_defines.svh"

module safeguarded_newton_root_solver #(
    parameter int FRACTION_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  snr_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output snr_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [snr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [snr_pkg::TOL_W-1:0]         cfg_data
);

    localparam int F     = FRACTION_BITS;
    localparam int XW    = F + 1;
    localparam int SW    = F + 3;
    localparam int UP    = (F >= 24) ? (F - 24) : 0;
    localparam int DOWN  = (F < 24) ? (24 - F) : 0;
    localparam int TQW   = snr_pkg::TOL_W + UP;
    localparam int CMPW  = (XW > TQW) ? XW : TQW;
    localparam int RW    = XW + DOWN;
    localparam int DW    = snr_pkg::DIV_W;
    localparam int CW    = snr_pkg::COEF_W;
    localparam logic [XW-1:0] ONE_Q    = {1'b1, {F{1'b0}}};
    localparam logic [XW-1:0] HALF_Q   = {2'b01, {(F-1){1'b0}}};
    localparam logic [SW-1:0] STEP_CAP = {1'b1, {(F+2){1'b0}}};

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_CHECK     = 12'b0000_0000_0010,
        S_MUL1      = 12'b0000_0000_0100,
        S_MUL2      = 12'b0000_0000_1000,
        S_MUL3      = 12'b0000_0001_0000,
        S_DIV_RATIO = 12'b0000_0010_0000,
        S_DIV_N1    = 12'b0000_0100_0000,
        S_DIV_D2    = 12'b0000_1000_0000,
        S_DG        = 12'b0001_0000_0000,
        S_DIV_STEP  = 12'b0010_0000_0000,
        S_UPDATE    = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    state_t                            state_reg;
    logic [snr_pkg::TOL_W-1:0]         tol_reg;
    logic [snr_pkg::STEPS_W-1:0]       lim_reg;
    logic [CW-1:0]                     c1_reg, c2_reg, c3_reg, t1_reg;
    logic [XW-1:0]                     x_reg, prev_reg, lo_reg, hi_reg, x2_reg;
    logic [snr_pkg::STEPS_W-1:0]       steps_reg;
    logic                              pos_reg, leave_reg;
    logic [DW-1:0]                     mag_reg, d2_reg;
    logic [SW-1:0]                     step_reg;
    snr_pkg::out_item_t                out_reg;

    // Shared units
    logic                              mul_en;
    logic [snr_pkg::MUL_A_W-1:0]       mul_a;
    logic [snr_pkg::MUL_B_W-1:0]       mul_b;
    logic [snr_pkg::PROD_W-1:0]        mul_prod;
    snr_pkg::div_req_t                 div_req;
    logic [DW-1:0]                     div_rem, div_dvd, div_dsr, div_quo;
    logic                              div_done;

    // Datapath helpers
    logic                              x_one;
    logic [XW-1:0]                     den, diff;
    logic [CMPW-1:0]                   tol_q;
    logic                              go;
    logic [RW-1:0]                     root_wide;
    logic [F+1:0]                      s_val;
    logic [DW-1:0]                     sum, mag_now, dg;
    logic                              pos_now, cs_over, n1_over, cap;
    logic [DW:0]                       dg_sum;
    logic [XW-1:0]                     room_lo, room_hi, lo_n, hi_n, x_n;
    logic [XW:0]                       mid;
    logic                              lv;

    // Loop test, output form and residual arithmetic
    always_comb
    begin
        x_one     = x_reg[F];
        den       = ONE_Q - x2_reg;
        diff      = (x_reg > prev_reg) ? (x_reg - prev_reg) : (prev_reg - x_reg);
        tol_q     = CMPW'((TQW'(tol_reg) << UP) >> DOWN);
        go        = (CMPW'(diff) > tol_q) && (steps_reg < lim_reg);
        root_wide = (RW'(x_reg) >> UP) << DOWN;
        s_val     = (F+2)'(ONE_Q) + (F+2)'(x2_reg);
        sum       = DW'(t1_reg) + div_quo;
        pos_now   = sum > DW'(c3_reg);
        mag_now   = pos_now ? (sum - DW'(c3_reg)) : (DW'(c3_reg) - sum);
        cs_over   = |mul_prod[snr_pkg::PROD_W-1:DW];
        n1_over   = |div_quo[DW-1:DW-F];
        dg_sum    = (DW+1)'(c1_reg) + (DW+1)'(d2_reg);
        dg        = dg_sum[DW] ? '1 : dg_sum[DW-1:0];
        cap       = {2'b00, mag_reg} >= {dg, 2'b00};
    end

    // Newton move or bisection of the bracket
    always_comb
    begin
        room_lo = x_reg - lo_reg;
        room_hi = hi_reg - x_reg;
        lv      = leave_reg || (pos_reg ? (step_reg > SW'(room_lo))
                                        : (step_reg > SW'(room_hi)));
        lo_n    = (lv && !pos_reg) ? prev_reg : lo_reg;
        hi_n    = (lv && pos_reg) ? prev_reg : hi_reg;
        mid     = (XW+1)'(lo_n) + (XW+1)'(hi_n);
        if (lv)
        begin
            x_n = mid[XW:1];
        end
        else if (pos_reg)
        begin
            x_n = x_reg - step_reg[XW-1:0];
        end
        else
        begin
            x_n = x_reg + step_reg[XW-1:0];
        end
    end

    // Drive the shared multiplier
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = snr_pkg::MUL_A_W'(x_reg);
        mul_b  = snr_pkg::MUL_B_W'(x_reg);
        case (state_reg)
            S_CHECK:
            begin
                mul_en = go;
            end
            S_MUL1:
            begin
                mul_en = 1'b1;
                mul_a  = c1_reg;
            end
            S_MUL2:
            begin
                mul_en = 1'b1;
                mul_a  = c2_reg;
            end
            S_MUL3:
            begin
                mul_en = 1'b1;
                mul_a  = c2_reg;
                mul_b  = snr_pkg::MUL_B_W'(s_val);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Drive the shared divider
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.count = snr_pkg::DIV_CNT_W'(DW);
        div_rem       = '0;
        div_dvd       = mul_prod[DW-1:0];
        div_dsr       = DW'(den);
        case (state_reg)
            S_MUL3:
            begin
                div_req.start = 1'b1;
                div_req.count = snr_pkg::DIV_CNT_W'(CW + F);
                div_dvd       = mul_prod[DW-1:0] << (CW - F);
            end
            S_DIV_RATIO:
            begin
                div_req.start = div_done && !cs_over;
            end
            S_DIV_N1:
            begin
                div_req.start = div_done && !n1_over;
                div_dvd       = div_quo << F;
            end
            S_DG:
            begin
                div_req.start = (dg != '0) && !cap;
                div_req.count = snr_pkg::DIV_CNT_W'(F + 2);
                div_rem       = mag_reg >> 2;
                div_dvd       = {mag_reg[1:0], {(DW-2){1'b0}}};
                div_dsr       = dg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    snr_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    snr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= snr_pkg::TOL_RESET;
            lim_reg <= snr_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                snr_pkg::CFG_TOLERANCE:  tol_reg <= cfg_data;
                snr_pkg::CFG_ITER_LIMIT: lim_reg <= cfg_data[snr_pkg::STEPS_W-1:0];
                default:                 tol_reg <= tol_reg;
            endcase
        end
    end

    // Sequence one solve
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:      if (in_valid) state_reg <= S_CHECK;
                S_CHECK:     state_reg <= go ? S_MUL1 : S_DONE;
                S_MUL1:      state_reg <= S_MUL2;
                S_MUL2:      state_reg <= x_one ? S_UPDATE : S_MUL3;
                S_MUL3:      state_reg <= S_DIV_RATIO;
                S_DIV_RATIO: if (div_done) state_reg <= cs_over ? S_DG : S_DIV_N1;
                S_DIV_N1:    if (div_done) state_reg <= n1_over ? S_DG : S_DIV_D2;
                S_DIV_D2:    if (div_done) state_reg <= S_DG;
                S_DG:
                begin
                    if ((dg == '0) || cap)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        state_reg <= S_DIV_STEP;
                    end
                end
                S_DIV_STEP:  if (div_done) state_reg <= S_UPDATE;
                S_UPDATE:    state_reg <= S_CHECK;
                S_DONE:      if (!out_stall) state_reg <= S_IDLE;
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    // Advance the iterate and its bracket
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                c1_reg    <= in_data.coef_linear;
                c2_reg    <= in_data.coef_ratio;
                c3_reg    <= in_data.target_value;
                x_reg     <= HALF_Q;
                prev_reg  <= ONE_Q;
                lo_reg    <= '0;
                hi_reg    <= ONE_Q;
                steps_reg <= '0;
            end
            S_CHECK:
            begin
                if (go)
                begin
                    prev_reg <= x_reg;
                end
                out_reg.root          <= root_wide[snr_pkg::ROOT_W-1:0];
                out_reg.steps_taken   <= steps_reg;
                out_reg.limit_reached <= CMPW'(diff) > tol_q;
            end
            S_MUL1:
            begin
                x2_reg <= x_one ? ONE_Q : XW'(mul_prod >> F);
            end
            S_MUL2:
            begin
                t1_reg <= x_one ? c1_reg : CW'(mul_prod >> F);
                if (x_one)
                begin
                    pos_reg   <= (c2_reg != '0) || (c1_reg > c3_reg);
                    leave_reg <= 1'b1;
                end
            end
            S_DIV_RATIO:
            begin
                if (div_done)
                begin
                    pos_reg <= pos_now;
                    mag_reg <= mag_now;
                    d2_reg  <= '1;
                end
            end
            S_DIV_N1:
            begin
                if (div_done)
                begin
                    d2_reg <= '1;
                end
            end
            S_DIV_D2:
            begin
                if (div_done)
                begin
                    d2_reg <= div_quo;
                end
            end
            S_DG:
            begin
                leave_reg <= (dg == '0);
                step_reg  <= STEP_CAP;
            end
            S_DIV_STEP:
            begin
                if (div_done)
                begin
                    step_reg <= SW'(div_quo);
                end
            end
            S_UPDATE:
            begin
                x_reg     <= x_n;
                lo_reg    <= lo_n;
                hi_reg    <= hi_n;
                steps_reg <= steps_reg + snr_pkg::STEPS_W'(1);
            end
            default:
            begin
                steps_reg <= steps_reg;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    `SNR_ASSERT_NOW(a_bracket, state_reg == S_CHECK, (lo_reg <= x_reg) && (x_reg <= hi_reg) && (hi_reg <= ONE_Q))
    `SNR_ASSERT_NOW(a_steps, state_reg == S_CHECK, steps_reg <= lim_reg)
    `SNR_ASSERT_NOW(a_div_done, div_done, (state_reg == S_DIV_RATIO) || (state_reg == S_DIV_N1) || (state_reg == S_DIV_D2) || (state_reg == S_DIV_STEP))
    `SNR_ASSERT_NEXT(a_accept, in_valid && !in_stall, state_reg == S_CHECK)

endmodule
